FILE: src/hduf_pkg.sv
// Package for the half-duplex UART FIFO control unit.
// Holds FIFO sizes, command codes and the bit-mirror and pointer helpers.
// No dependencies.
package hduf_pkg;

	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 16;
	localparam int RX_PTR_W = $clog2(RX_DEPTH);
	localparam int TX_PTR_W = $clog2(TX_DEPTH);

	typedef enum logic [1:0] {
		CMD_HOST_WRITE = 2'd0,
		CMD_HOST_READ  = 2'd1,
		CMD_LINE_START = 2'd2,
		CMD_SHIFT_DONE = 2'd3
	} cmd_t;

	localparam logic [7:0] HALF1_MARK = 8'h80;
	localparam logic [7:0] HALF2_MARK = 8'h07;

	function automatic logic [7:0] mirror8(input logic [7:0] v);
		logic [7:0] t;
		t = ((v >> 1) & 8'h55) | ((v << 1) & 8'haa);
		t = ((t >> 2) & 8'h33) | ((t << 2) & 8'hcc);
		t = ((t >> 4) & 8'h0f) | ((t << 4) & 8'hf0);
		return t;
	endfunction

	function automatic logic [RX_PTR_W-1:0] bump_rx(input logic [RX_PTR_W-1:0] p);
		return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_PTR_W-1:0] bump_tx(input logic [TX_PTR_W-1:0] p);
		return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

FILE: src/hduf_chan_if.sv
// Valid/ready channel interfaces of the half-duplex UART FIFO control unit.
// Request channel carries commands, response channel carries results.
// Depends on nothing.
interface hduf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] host_byte;
	logic [7:0] line_word;

	modport source (output valid, cmd, host_byte, line_word, input ready);
	modport sink (input valid, cmd, host_byte, line_word, output ready);
endinterface

interface hduf_rsp_if;
	logic       valid;
	logic       ready;
	logic       read_valid;
	logic [7:0] read_byte;
	logic       write_rejected;
	logic       shift_valid;
	logic [7:0] shift_word;
	logic       drive_enable;
	logic       rx_overflow;
	logic       rx_not_empty;
	logic       tx_not_empty;

	modport source (output valid, read_valid, read_byte, write_rejected, shift_valid,
		shift_word, drive_enable, rx_overflow, rx_not_empty, tx_not_empty, input ready);
	modport sink (input valid, read_valid, read_byte, write_rejected, shift_valid,
		shift_word, drive_enable, rx_overflow, rx_not_empty, tx_not_empty, output ready);
endinterface

FILE: src/half_duplex_uart_fifo_control_unit.sv
// Half-duplex UART FIFO control unit: TX and RX ring FIFOs in synchronous RAMs.
// Depends on hduf_pkg and the channel interfaces in hduf_chan_if.sv.
// An accepted item goes through the registered RAM read, then the update and result registers in S_EXEC.
// No new item is taken while one is in S_EXEC; each item needs its registered RAM read.
// A new item is taken once the previous result has been taken or is taken that cycle.
// Reset (arst_n low) clears pointers and flags at once; RAM contents stay undefined.
module half_duplex_uart_fifo_control_unit (
	input  logic       clk,
	input  logic       arst_n,
	hduf_req_if.sink   req,
	hduf_rsp_if.source rsp
);

	localparam int RXW = hduf_pkg::RX_PTR_W;
	localparam int TXW = hduf_pkg::TX_PTR_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} st_t;

	logic [7:0] rx_mem [hduf_pkg::RX_DEPTH];
	logic [7:0] tx_mem [hduf_pkg::TX_DEPTH];

	st_t            st_q;
	hduf_pkg::cmd_t cmd_q;
	logic [7:0]     hbyte_q, lword_q, rx_rd_q, tx_rd_q, cur_q;
	logic [RXW-1:0] rx_wp_q, rx_rp_q;
	logic [TXW-1:0] tx_wp_q, tx_rp_q;
	logic           xmit_q, half2_q, recv_q, pend_q, ovf_q;

	logic           out_valid_q, rvalid_q, wrej_q, svalid_q;
	logic [7:0]     rbyte_q, sword_q;

	logic           accept;
	logic [RXW-1:0] rx_wp_n, rx_rp_n, rx_wnx, rx_rnx;
	logic [TXW-1:0] tx_wp_n, tx_rp_n, tx_wnx, tx_rnx;
	logic           xmit_n, half2_n, recv_n, pend_n, ovf_n;
	logic [7:0]     cur_n;
	logic           rvalid_n, wrej_n, svalid_n, rx_we, tx_we;
	logic [7:0]     rbyte_n, sword_n;

	assign req.ready = (st_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign rx_wnx = hduf_pkg::bump_rx(rx_wp_q);
	assign rx_rnx = hduf_pkg::bump_rx(rx_rp_q);
	assign tx_wnx = hduf_pkg::bump_tx(tx_wp_q);
	assign tx_rnx = hduf_pkg::bump_tx(tx_rp_q);

	always_comb begin
		rx_wp_n  = rx_wp_q;
		rx_rp_n  = rx_rp_q;
		tx_wp_n  = tx_wp_q;
		tx_rp_n  = tx_rp_q;
		xmit_n   = xmit_q;
		half2_n  = half2_q;
		recv_n   = recv_q;
		pend_n   = pend_q;
		ovf_n    = ovf_q;
		cur_n    = cur_q;
		rvalid_n = 1'b0;
		rbyte_n  = '0;
		wrej_n   = 1'b0;
		svalid_n = 1'b0;
		sword_n  = '0;
		rx_we    = 1'b0;
		tx_we    = 1'b0;
		unique case (cmd_q)
			hduf_pkg::CMD_HOST_WRITE: begin
				if (tx_wnx == tx_rp_q) begin
					wrej_n = 1'b1;
				end else begin
					tx_we   = 1'b1;
					tx_wp_n = tx_wnx;
					if (!xmit_q) begin
						if (recv_q) pend_n = 1'b1;
						else        xmit_n = 1'b1;
					end
				end
			end
			hduf_pkg::CMD_HOST_READ: begin
				if (rx_rp_q != rx_wp_q) begin
					rx_rp_n  = rx_rnx;
					rvalid_n = 1'b1;
					rbyte_n  = hduf_pkg::mirror8(rx_rd_q);
				end
			end
			hduf_pkg::CMD_LINE_START: begin
				if (!xmit_q) recv_n = 1'b1;
			end
			hduf_pkg::CMD_SHIFT_DONE: begin
				if (xmit_q) begin
					if (half2_q) begin
						half2_n  = 1'b0;
						svalid_n = 1'b1;
						sword_n  = {cur_q[4:0], 3'b000} | hduf_pkg::HALF2_MARK;
					end else if (tx_rp_q != tx_wp_q) begin
						tx_rp_n  = tx_rnx;
						cur_n    = tx_rd_q;
						half2_n  = 1'b1;
						svalid_n = 1'b1;
						sword_n  = {2'b00, tx_rd_q[7:2]} | hduf_pkg::HALF1_MARK;
					end else begin
						xmit_n = 1'b0;
					end
				end else if (recv_q) begin
					recv_n = 1'b0;
					if (rx_wnx == rx_rp_q) begin
						ovf_n = 1'b1;
					end else begin
						rx_we   = 1'b1;
						rx_wp_n = rx_wnx;
					end
					if (pend_q) begin
						pend_n = 1'b0;
						xmit_n = 1'b1;
					end
				end
			end
		endcase
	end

	// RAM ports: read at accept, write back during execute
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_rd_q <= rx_mem[rx_rnx];
			tx_rd_q <= tx_mem[tx_rnx];
			cmd_q   <= hduf_pkg::cmd_t'(req.cmd);
			hbyte_q <= req.host_byte;
			lword_q <= req.line_word;
		end
		if (st_q == S_EXEC && rx_we) rx_mem[rx_wnx] <= lword_q;
		if (st_q == S_EXEC && tx_we) tx_mem[tx_wnx] <= hduf_pkg::mirror8(hbyte_q);
		if (st_q == S_EXEC) begin
			cur_q    <= cur_n;
			rvalid_q <= rvalid_n;
			rbyte_q  <= rbyte_n;
			wrej_q   <= wrej_n;
			svalid_q <= svalid_n;
			sword_q  <= sword_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
			rx_wp_q     <= '0;
			rx_rp_q     <= '0;
			tx_wp_q     <= '0;
			tx_rp_q     <= '0;
			xmit_q      <= 1'b0;
			half2_q     <= 1'b0;
			recv_q      <= 1'b0;
			pend_q      <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (rsp.ready) out_valid_q <= 1'b0;
					if (accept)    st_q        <= S_EXEC;
				end
				S_EXEC: begin
					st_q        <= S_IDLE;
					out_valid_q <= 1'b1;
					rx_wp_q     <= rx_wp_n;
					rx_rp_q     <= rx_rp_n;
					tx_wp_q     <= tx_wp_n;
					tx_rp_q     <= tx_rp_n;
					xmit_q      <= xmit_n;
					half2_q     <= half2_n;
					recv_q      <= recv_n;
					pend_q      <= pend_n;
					ovf_q       <= ovf_n;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_valid     = rvalid_q;
	assign rsp.read_byte      = rbyte_q;
	assign rsp.write_rejected = wrej_q;
	assign rsp.shift_valid    = svalid_q;
	assign rsp.shift_word     = sword_q;
	assign rsp.drive_enable   = xmit_q;
	assign rsp.rx_overflow    = ovf_q;
	assign rsp.rx_not_empty   = (rx_rp_q != rx_wp_q);
	assign rsp.tx_not_empty   = (tx_rp_q != tx_wp_q);

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EXEC) |-> !out_valid_q)
		else $error("result register still full when an item executes");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EXEC) |=> (out_valid_q && st_q == S_IDLE))
		else $error("execute did not produce a result");

	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(xmit_q && recv_q))
		else $error("transmit and receive active together");

	a_pending_needs_rx: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> recv_q)
		else $error("deferred transmit start without a running reception");

	a_half2_in_tx: assert property (@(posedge clk) disable iff (!arst_n)
		half2_q |-> xmit_q)
		else $error("second half-frame due outside transmit mode");

endmodule
